/* sv/i2c_master_byte_engine_defines.svh */
// Assertion macros shared by the I2C master byte engine RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define I2CM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another one in the next cycle.
`define I2CM_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) else $error(msg);

`endif

/* sv/i2cm_pkg.sv */
// Shared types and constants of the I2C master byte engine.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package i2cm_pkg;

    // Width and reset value of the quarter-bit delay register.
    localparam int QP_W = 16;
    localparam logic [QP_W-1:0] QP_RESET = 16'd3000;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Function codes on the input channel.
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Input item as it arrives on the port.
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
        logic       scl_in;
    } t_item;

    // Result item as it leaves on the port.
    typedef struct packed {
        logic       sda_release;
        logic       scl_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
        logic       cmd_error;
    } t_result;

    // Classified item kind produced by the front.
    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_START = 3'd1,
        K_STOP  = 3'd2,
        K_WRITE = 3'd3,
        K_READ  = 3'd4
    } t_kind;

    // Classified item carried through the queue.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
        logic       scl_in;
    } t_cmd;

    // Line sequencer phases, one-hot.
    typedef enum logic [12:0] {
        PH_IDLE  = 13'b0000000000001,
        PH_STA1  = 13'b0000000000010,
        PH_STA2  = 13'b0000000000100,
        PH_STA3  = 13'b0000000001000,
        PH_STO1  = 13'b0000000010000,
        PH_STO2  = 13'b0000000100000,
        PH_STO3  = 13'b0000001000000,
        PH_WLOW  = 13'b0000010000000,
        PH_WRISE = 13'b0000100000000,
        PH_WHIGH = 13'b0001000000000,
        PH_RLOW  = 13'b0010000000000,
        PH_RRISE = 13'b0100000000000,
        PH_RHIGH = 13'b1000000000000
    } t_phase;

endpackage

`default_nettype wire

/* sv/i2c_master_byte_engine.sv */
// I2C master byte engine top level: front stage, queue and back stage.
// Depends on i2cm_pkg, i2cm_front, i2cm_fifo and i2cm_back.
//
// Usage: the input channel carries one item per transaction: a timing tick with
// the sampled SDA and SCL levels, or a start, stop, write-byte or read-byte
// command. Every accepted item yields exactly one result transaction with the
// line drive levels, busy and done flags, the last received byte, the write
// acknowledge status and a flag for a command refused while busy.
// An accepted item passes the front holding register and the queue, and the
// sequencer step writes its result into the result register.
// Throughput: one item per cycle unless the receiver stalls; the sequencer
// retires one item per cycle and the quarter-bit delay counter advances once
// per tick item. The queue between front and back holds QUEUE_DEPTH items, so
// the input side keeps accepting while a result waits; once the receiver stalls
// long enough for the queue and the front register to fill, o_in_stall rises.
// Reset: synchronous, active low; releases both lines, idles the sequencer and
// resets the quarter period to 3000, which the user writes via i_cfg_wr_en and
// i_cfg_wr_data only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module i2c_master_byte_engine #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [i2cm_pkg::QP_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire i2cm_pkg::t_item           i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output i2cm_pkg::t_result              o_out_res
);
    import i2cm_pkg::*;

    logic  w_fifo_full;
    logic  w_push;
    t_cmd  w_push_cmd;
    logic  w_fifo_valid;
    t_cmd  w_head;
    logic  w_pop;

    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_fifo_full (w_fifo_full),
        .o_push      (w_push),
        .o_push_cmd  (w_push_cmd)
    );

    i2cm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_fifo_full),
        .o_valid    (w_fifo_valid),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fifo_valid  (w_fifo_valid),
        .i_cmd         (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_res     (o_out_res)
    );

endmodule

`default_nettype wire

/* sv/i2cm_front.sv */
// Front stage of the I2C master byte engine: accepts input items and classifies them.
// Depends on i2cm_pkg; feeds the queue in i2cm_fifo.
`default_nettype none

module i2cm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire i2cm_pkg::t_item i_in_item,
    input  wire logic           i_fifo_full,
    output logic                o_push,
    output i2cm_pkg::t_cmd      o_push_cmd
);
    import i2cm_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_cmd   r_cmd;
    t_cmd   w_cmd;
    logic   w_accept;

    // Map the function code onto a command kind; unused codes behave as ticks.
    always_comb begin
        w_cmd.data_byte = i_in_item.data_byte;
        w_cmd.send_ack  = i_in_item.send_ack;
        w_cmd.sda_in    = i_in_item.sda_in;
        w_cmd.scl_in    = i_in_item.scl_in;
        unique case (i_in_item.func)
            FUNC_START: w_cmd.kind = K_START;
            FUNC_STOP:  w_cmd.kind = K_STOP;
            FUNC_WRITE: w_cmd.kind = K_WRITE;
            FUNC_READ:  w_cmd.kind = K_READ;
            default:    w_cmd.kind = K_TICK;
        endcase
    end

    // The holding register empties into the queue whenever the queue has room.
    assign o_push     = r_valid && !i_fifo_full;
    assign o_push_cmd = r_cmd;
    assign o_in_stall = r_valid && i_fifo_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/i2cm_fifo.sv */
// Short queue of classified items between the front and the back of the engine.
// Depends on i2cm_pkg for the item type and the assertion macro header.
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"

module i2cm_fifo #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire i2cm_pkg::t_cmd i_push_cmd,
    output logic                o_full,
    output logic                o_valid,
    output i2cm_pkg::t_cmd      o_head,
    input  wire logic           i_pop
);
    import i2cm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers wrap at the queue depth, which need not be a power of two.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // The fill level never passes the depth.
    `I2CM_ASSERT(a_fifo_count, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue overfilled")

endmodule

`default_nettype wire

/* sv/i2cm_back.sv */
// Back stage of the I2C master byte engine: phase sequencer, delay counter and result register.
// Depends on i2cm_pkg and the assertion macro header; takes items from i2cm_fifo.
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"

module i2cm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [i2cm_pkg::QP_W-1:0]     i_cfg_wr_data,
    input  wire logic                          i_fifo_valid,
    input  wire i2cm_pkg::t_cmd                i_cmd,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output i2cm_pkg::t_result                  o_out_res
);
    import i2cm_pkg::*;

    // Configuration and sequencer state.
    logic [QP_W-1:0] r_qp;
    t_phase          r_phase;
    t_phase          n_phase;
    logic [3:0]      r_bit_count;
    logic [3:0]      n_bit_count;
    logic [7:0]      r_shift;
    logic [7:0]      n_shift;
    logic [QP_W-1:0] r_delay;
    logic [QP_W-1:0] n_delay;
    logic            r_sda;
    logic            n_sda;
    logic            r_scl;
    logic            n_scl;
    logic            r_ack;
    logic            n_ack;
    logic [7:0]      r_last_rx;
    logic [7:0]      n_last_rx;

    // Result register.
    logic            r_out_valid;
    t_result         r_out;

    // Helper terms.
    logic [QP_W-1:0] w_q;
    logic            w_elapsed;
    logic [QP_W-1:0] w_delay_step;
    logic            w_reading;
    logic [3:0]      w_bc_inc;
    logic [7:0]      w_shift_nx;
    logic            w_done;
    logic            w_nack;
    logic            w_err;

    // One item is retired per cycle whenever the result register can take it.
    assign o_pop = i_fifo_valid && (!r_out_valid || !i_out_stall);

    // A timed phase lasts the configured number of ticks; zero counts as one.
    assign w_q          = (r_qp == '0) ? QP_W'(1) : r_qp;
    assign w_elapsed    = ({1'b0, r_delay} + (QP_W + 1)'(1)) >= {1'b0, w_q};
    assign w_delay_step = w_elapsed ? '0 : r_delay + QP_W'(1);
    assign w_reading    = (r_phase == PH_RLOW) || (r_phase == PH_RRISE)
                          || (r_phase == PH_RHIGH);
    assign w_bc_inc     = r_bit_count + 4'd1;
    assign w_shift_nx   = {r_shift[6:0], w_reading ? i_cmd.sda_in : 1'b0};

    // Next state of the line sequencer.
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_delay     = r_delay;
        n_sda       = r_sda;
        n_scl       = r_scl;
        n_ack       = r_ack;
        n_last_rx   = r_last_rx;
        w_done      = 1'b0;
        w_nack      = 1'b0;
        w_err       = 1'b0;
        if (i_cmd.kind != K_TICK) begin
            // A command is taken only when the sequencer is idle.
            if (r_phase != PH_IDLE) begin
                w_err = 1'b1;
            end else begin
                n_delay = '0;
                unique case (i_cmd.kind)
                    K_START: begin
                        n_phase = PH_STA1;
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                    end
                    K_STOP: begin
                        n_phase = PH_STO1;
                        n_sda   = 1'b0;
                        n_scl   = 1'b0;
                    end
                    K_WRITE: begin
                        n_bit_count = '0;
                        n_shift     = i_cmd.data_byte;
                        n_ack       = ~i_cmd.send_ack;
                        n_phase     = PH_WLOW;
                        n_scl       = 1'b0;
                        n_sda       = i_cmd.data_byte[7];
                    end
                    K_READ: begin
                        n_bit_count = '0;
                        n_shift     = '0;
                        n_ack       = ~i_cmd.send_ack;
                        n_phase     = PH_RLOW;
                        n_scl       = 1'b0;
                        n_sda       = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end else begin
            unique case (r_phase)
                PH_STA1: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_phase = PH_STA2;
                        n_sda   = 1'b0;
                    end
                end
                PH_STA2: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_phase = PH_STA3;
                        n_scl   = 1'b0;
                    end
                end
                PH_STA3, PH_STO3: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end
                end
                PH_STO1: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_phase = PH_STO2;
                        n_scl   = 1'b1;
                    end
                end
                PH_STO2: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_phase = PH_STO3;
                        n_sda   = 1'b1;
                    end
                end
                PH_WLOW, PH_RLOW: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_phase = w_reading ? PH_RRISE : PH_WRISE;
                        n_scl   = 1'b1;
                    end
                end
                // Wait here while the slave holds SCL low.
                PH_WRISE, PH_RRISE: begin
                    if (i_cmd.scl_in) begin
                        n_phase = w_reading ? PH_RHIGH : PH_WHIGH;
                        n_delay = '0;
                    end
                end
                // SDA is sampled at the end of the high phase.
                PH_WHIGH, PH_RHIGH: begin
                    n_delay = w_delay_step;
                    if (w_elapsed) begin
                        n_scl = 1'b0;
                        if (r_bit_count[3]) begin
                            n_phase     = PH_IDLE;
                            w_done      = 1'b1;
                            n_bit_count = '0;
                            if (w_reading) begin
                                n_last_rx = r_shift;
                                n_sda     = 1'b1;
                            end else begin
                                w_nack = i_cmd.sda_in;
                                n_sda  = 1'b0;
                            end
                        end else begin
                            n_shift     = w_shift_nx;
                            n_bit_count = w_bc_inc;
                            n_phase     = w_reading ? PH_RLOW : PH_WLOW;
                            // Data bit, or the acknowledge slot after the eighth bit.
                            if (w_bc_inc[3]) begin
                                n_sda = w_reading ? r_ack : 1'b1;
                            end else begin
                                n_sda = w_reading ? 1'b1 : r_shift[6];
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qp <= QP_RESET;
        end else if (i_cfg_wr_en) begin
            r_qp <= i_cfg_wr_data;
        end
    end

    // Sequencer state advances on each retired item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_delay     <= '0;
            r_sda       <= 1'b1;
            r_scl       <= 1'b1;
            r_ack       <= 1'b0;
            r_last_rx   <= '0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_delay     <= n_delay;
            r_sda       <= n_sda;
            r_scl       <= n_scl;
            r_ack       <= n_ack;
            r_last_rx   <= n_last_rx;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.sda_release <= n_sda;
            r_out.scl_release <= n_scl;
            r_out.busy_res    <= (n_phase != PH_IDLE);
            r_out.done_res    <= w_done;
            r_out.rx_byte     <= n_last_rx;
            r_out.nack_seen   <= w_nack;
            r_out.cmd_error   <= w_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // A finished command always leaves the sequencer idle.
    `I2CM_ASSERT(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res |-> !r_out.busy_res, "done while busy")
    // A rejected command never completes anything.
    `I2CM_ASSERT(a_err_nodone, i_clk, i_rst_n, r_out_valid && r_out.cmd_error |-> !r_out.done_res, "error with done")
    // The bit counter is cleared whenever the sequencer rests.
    `I2CM_ASSERT(a_idle_count, i_clk, i_rst_n, r_phase != PH_IDLE || r_bit_count == 4'd0, "bit count not cleared")
    // While SCL is stretched the rise phase holds.
    `I2CM_ASSERT_NEXT(a_stretch, i_clk, i_rst_n, o_pop && i_cmd.kind == K_TICK && !i_cmd.scl_in && (r_phase == PH_WRISE || r_phase == PH_RRISE), $stable(r_phase), "left rise phase while stretched")

endmodule

`default_nettype wire
